/* rtl/sng_pkg.sv */
package sng_pkg;

    // Coordinate width of cell and node indexes.
    localparam int COORD_BITS = 12;
    // Grid size registers hold one bit more than a coordinate.
    localparam int SIZE_BITS = COORD_BITS + 1;
    localparam int DOF_BITS = 4;
    localparam int KIND_BITS = 2;
    localparam int WIDTH_BITS = 2;
    // Widest box half width; the star supports at most STAR_MAX_W.
    localparam int MAX_WIDTH = 3;
    localparam int STAR_MAX_W = 2;
    localparam int STAR_SMALL_NODES = 5;
    localparam int STAR_NODES = 13;
    localparam int STEP_BITS = $clog2(STAR_NODES);
    localparam int OFS_BITS = $clog2(2 * MAX_WIDTH + 1);
    localparam int JOB_DEPTH = 2;
    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS = SIZE_BITS;

    typedef logic [COORD_BITS-1:0] coord_t;
    typedef logic [DOF_BITS-1:0] dof_t;
    typedef logic [SIZE_BITS-1:0] size_t;
    typedef logic signed [COORD_BITS+1:0] scoord_t;
    typedef logic signed [2:0] delta_t;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_KIND  = 3'd0,
        REG_WIDTH = 3'd1,
        REG_EDGE  = 3'd2,
        REG_CELL  = 3'd3,
        REG_COLS  = 3'd4,
        REG_ROWS  = 3'd5
    } cfg_reg_t;

    typedef enum logic [KIND_BITS-1:0] {
        KIND_STAR    = 2'd0,
        KIND_BOX     = 2'd1,
        KIND_CENTRAL = 2'd2
    } stencil_kind_t;

    typedef enum logic [2:0] {
        JOB_SINGLE  = 3'd0,
        JOB_ERROR   = 3'd1,
        JOB_STAR5   = 3'd2,
        JOB_STAR13  = 3'd3,
        JOB_BOX     = 3'd4
    } job_kind_t;

    typedef struct packed {
        logic [KIND_BITS-1:0]  kind;
        logic [WIDTH_BITS-1:0] width;
        dof_t                  edge_dofs;
        dof_t                  cell_dofs;
        size_t                 cols;
        size_t                 rows;
    } cfg_t;

    // One classified center cell: everything the back end needs to walk it.
    typedef struct packed {
        job_kind_t kind;
        coord_t    cx;
        coord_t    cy;
        coord_t    hx;
        coord_t    hy;
        coord_t    sx;
        coord_t    sy;
        coord_t    ex;
        coord_t    ey;
        dof_t      edge_dofs;
        dof_t      cell_dofs;
    } job_t;

    typedef struct packed {
        coord_t px;
        coord_t py;
        dof_t   edge_dofs;
        dof_t   cell_dofs;
        logic   unsupported;
        logic   last;
    } result_t;

    // Largest legal coordinate for a grid of n cells, saturated to the coordinate range.
    function automatic coord_t upper_bound(input size_t n);
        size_t m;
        coord_t r;
        m = n - size_t'(1);
        if (n == '0) begin
            r = '0;
        end else if (m[COORD_BITS]) begin
            r = '1;
        end else begin
            r = m[COORD_BITS-1:0];
        end
        return r;
    endfunction

    function automatic coord_t clamp(input scoord_t v, input coord_t hi);
        coord_t r;
        if (v < 0) begin
            r = '0;
        end else if (v > $signed({2'b00, hi})) begin
            r = hi;
        end else begin
            r = v[COORD_BITS-1:0];
        end
        return r;
    endfunction

    function automatic delta_t star_dx(input logic wide, input logic [STEP_BITS-1:0] k);
        delta_t d;
        d = 3'sd0;
        if (wide) begin
            case (k)
                4'd1, 4'd5, 4'd9:  d = -3'sd1;
                4'd3, 4'd7, 4'd11: d = 3'sd1;
                4'd4:              d = -3'sd2;
                4'd8:              d = 3'sd2;
                default:           d = 3'sd0;
            endcase
        end else begin
            case (k)
                4'd1:    d = -3'sd1;
                4'd3:    d = 3'sd1;
                default: d = 3'sd0;
            endcase
        end
        return d;
    endfunction

    function automatic delta_t star_dy(input logic wide, input logic [STEP_BITS-1:0] k);
        delta_t d;
        d = 3'sd0;
        if (wide) begin
            case (k)
                4'd0:               d = 3'sd2;
                4'd1, 4'd2, 4'd3:   d = 3'sd1;
                4'd9, 4'd10, 4'd11: d = -3'sd1;
                4'd12:              d = -3'sd2;
                default:            d = 3'sd0;
            endcase
        end else begin
            case (k)
                4'd0:    d = 3'sd1;
                4'd4:    d = -3'sd1;
                default: d = 3'sd0;
            endcase
        end
        return d;
    endfunction

endpackage

/* rtl/sng_front.sv */
module sng_front (
    input  logic            push,
    output logic            full,
    input  sng_pkg::coord_t cell_x,
    input  sng_pkg::coord_t cell_y,
    input  sng_pkg::cfg_t   cfg,
    input  logic            q_full,
    output logic            q_push,
    output sng_pkg::job_t   job
);
    import sng_pkg::*;

    coord_t                hx;
    coord_t                hy;
    logic [WIDTH_BITS-1:0] w;
    coord_t                wc;
    logic [COORD_BITS:0]   ex_wide;
    logic [COORD_BITS:0]   ey_wide;
    coord_t                sx;
    coord_t                sy;
    coord_t                ex;
    coord_t                ey;
    logic                  keep;

    always_comb
    begin
        hx = upper_bound(cfg.cols);
        hy = upper_bound(cfg.rows);
        w = (cfg.width > WIDTH_BITS'(MAX_WIDTH)) ? WIDTH_BITS'(MAX_WIDTH) : cfg.width;
        wc = COORD_BITS'(w);

        sx = (cell_x >= wc) ? cell_x - wc : '0;
        sy = (cell_y >= wc) ? cell_y - wc : '0;
        ex_wide = {1'b0, cell_x} + {1'b0, wc};
        ey_wide = {1'b0, cell_y} + {1'b0, wc};
        ex = (ex_wide > {1'b0, hx}) ? hx : ex_wide[COORD_BITS-1:0];
        ey = (ey_wide > {1'b0, hy}) ? hy : ey_wide[COORD_BITS-1:0];

        job = '0;
        job.cx = cell_x;
        job.cy = cell_y;
        job.hx = hx;
        job.hy = hy;
        job.sx = sx;
        job.sy = sy;
        job.ex = ex;
        job.ey = ey;
        job.edge_dofs = cfg.edge_dofs;
        job.cell_dofs = cfg.cell_dofs;
        job.kind = JOB_SINGLE;
        keep = 1'b1;

        if (cfg.kind == KIND_STAR && cfg.width > WIDTH_BITS'(STAR_MAX_W)) begin
            job.kind = JOB_ERROR;
        end else if (cfg.edge_dofs == '0 && cfg.cell_dofs == '0) begin
            keep = 1'b0;
        end else begin
            case (cfg.kind)
                KIND_STAR:
                begin
                    if (cfg.width == '0) begin
                        // A star of width zero is the clamped center alone.
                        job.kind = JOB_SINGLE;
                        job.cx = (cell_x > hx) ? hx : cell_x;
                        job.cy = (cell_y > hy) ? hy : cell_y;
                    end else if (cfg.width == WIDTH_BITS'(1)) begin
                        job.kind = JOB_STAR5;
                    end else begin
                        job.kind = JOB_STAR13;
                    end
                end
                KIND_BOX:
                begin
                    job.kind = JOB_BOX;
                    // A center outside the grid can cross the bounds: nothing to emit.
                    keep = (sx <= ex) && (sy <= ey);
                end
                default:
                begin
                    job.kind = JOB_SINGLE;
                end
            endcase
        end
    end

    assign full = q_full;
    assign q_push = push && !q_full && keep;

endmodule

/* rtl/sng_queue.sv */
module sng_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          wr_en,
    input  sng_pkg::job_t wr_job,
    input  logic          rd_en,
    output sng_pkg::job_t rd_job,
    output logic          q_empty,
    output logic          q_full
);
    import sng_pkg::*;

    localparam int PTR_BITS = (JOB_DEPTH > 1) ? $clog2(JOB_DEPTH) : 1;
    localparam int CNT_BITS = $clog2(JOB_DEPTH + 1);

    job_t                slot_reg [JOB_DEPTH];
    logic [PTR_BITS-1:0] wr_ptr_reg;
    logic [PTR_BITS-1:0] wr_ptr_next;
    logic [PTR_BITS-1:0] rd_ptr_reg;
    logic [PTR_BITS-1:0] rd_ptr_next;
    logic [CNT_BITS-1:0] count_reg;
    logic [CNT_BITS-1:0] count_next;

    assign q_empty = (count_reg == '0);
    assign q_full = (count_reg == CNT_BITS'(JOB_DEPTH));
    assign rd_job = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next = count_reg;
        if (wr_en) begin
            wr_ptr_next = (wr_ptr_reg == PTR_BITS'(JOB_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (rd_en) begin
            rd_ptr_next = (rd_ptr_reg == PTR_BITS'(JOB_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (wr_en && !rd_en) begin
            count_next = count_reg + 1'b1;
        end else if (rd_en && !wr_en) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en) begin
            slot_reg[wr_ptr_reg] <= wr_job;
        end
    end

endmodule

/* rtl/sng_back.sv */
module sng_back (
    input  logic             clk,
    input  logic             rst_n,
    input  sng_pkg::job_t    head,
    input  logic             head_valid,
    output logic             head_pop,
    input  logic             pop,
    output logic             out_valid,
    output sng_pkg::result_t out_res
);
    import sng_pkg::*;

    logic [STEP_BITS-1:0] k_reg;
    logic [STEP_BITS-1:0] k_next;
    logic [OFS_BITS-1:0]  ox_reg;
    logic [OFS_BITS-1:0]  ox_next;
    logic [OFS_BITS-1:0]  oy_reg;
    logic [OFS_BITS-1:0]  oy_next;
    logic                 out_valid_reg;
    logic                 out_valid_next;
    result_t              out_reg;
    result_t              node;
    logic                 advance;
    logic                 wide;
    scoord_t              vx;
    scoord_t              vy;
    logic [STEP_BITS-1:0] last_k;

    assign advance = head_valid && (!out_valid_reg || pop);
    assign head_pop = advance && node.last;
    assign out_valid = out_valid_reg;
    assign out_res = out_reg;

    always_comb
    begin
        wide = (head.kind == JOB_STAR13);
        last_k = wide ? STEP_BITS'(STAR_NODES - 1) : STEP_BITS'(STAR_SMALL_NODES - 1);
        vx = $signed({2'b00, head.cx}) + (COORD_BITS + 2)'(star_dx(wide, k_reg));
        vy = $signed({2'b00, head.cy}) + (COORD_BITS + 2)'(star_dy(wide, k_reg));

        node = '0;
        node.edge_dofs = head.edge_dofs;
        node.cell_dofs = head.cell_dofs;
        case (head.kind)
            JOB_STAR5, JOB_STAR13:
            begin
                node.px = clamp(vx, head.hx);
                node.py = clamp(vy, head.hy);
                node.last = (k_reg == last_k);
            end
            JOB_BOX:
            begin
                node.px = head.sx + COORD_BITS'(ox_reg);
                node.py = head.sy + COORD_BITS'(oy_reg);
                node.last = (node.px == head.ex) && (node.py == head.ey);
            end
            JOB_ERROR:
            begin
                node.edge_dofs = '0;
                node.cell_dofs = '0;
                node.unsupported = 1'b1;
                node.last = 1'b1;
            end
            default:
            begin
                node.px = head.cx;
                node.py = head.cy;
                node.last = 1'b1;
            end
        endcase

        k_next = k_reg;
        ox_next = ox_reg;
        oy_next = oy_reg;
        if (advance) begin
            if (node.last) begin
                k_next = '0;
                ox_next = '0;
                oy_next = '0;
            end else begin
                k_next = k_reg + 1'b1;
                if (node.px == head.ex) begin
                    ox_next = '0;
                    oy_next = oy_reg + 1'b1;
                end else begin
                    ox_next = ox_reg + 1'b1;
                end
            end
        end

        if (advance) begin
            out_valid_next = 1'b1;
        end else if (pop) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            k_reg <= '0;
            ox_reg <= '0;
            oy_reg <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            k_reg <= k_next;
            ox_reg <= ox_next;
            oy_reg <= oy_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance) begin
            out_reg <= node;
        end
    end

endmodule

/* rtl/stencil_neighbor_generator_core.sv */
// Channel   | Direction | Handshake             | Request contents
// ----------+-----------+-----------------------+----------------------------------------
// input     | in        | push / full           | cell_x, cell_y
// result    | out       | empty / pop           | point_x, point_y, node_edge_dofs,
//           |           |                       | node_cell_dofs, unsupported, last
// config    | in        | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// One node per cycle leaves the sequencer when not stalled: 1 node per cell for central,
// a star of width 0 or the error, 5 or 13 for a star, up to (2w+1)^2 = 49 for a box.
// A cell that yields nothing is dropped by the classifier and never enters the queue.
// Reset is asynchronous and active low; it empties the job queue and the result
// register and loads the register reset values, so no clearing pass is needed.
// A stalled result side fills the two-entry queue, and only then does full rise.
module stencil_neighbor_generator_core (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                push,
    output logic                                full,
    input  logic [sng_pkg::COORD_BITS-1:0]      cell_x,
    input  logic [sng_pkg::COORD_BITS-1:0]      cell_y,
    output logic                                empty,
    input  logic                                pop,
    output logic [sng_pkg::COORD_BITS-1:0]      point_x,
    output logic [sng_pkg::COORD_BITS-1:0]      point_y,
    output logic [sng_pkg::DOF_BITS-1:0]        node_edge_dofs,
    output logic [sng_pkg::DOF_BITS-1:0]        node_cell_dofs,
    output logic                                unsupported,
    output logic                                last,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [sng_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  logic [sng_pkg::CFG_DATA_BITS-1:0]   cfg_data
);
    import sng_pkg::*;

    // Configuration registers. The user must change them only while the block is idle (the
    // block does not enforce this), so the classifier may read them directly.
    logic [KIND_BITS-1:0]  kind_reg;
    logic [WIDTH_BITS-1:0] width_reg;
    dof_t                  edge_reg;
    dof_t                  cell_reg;
    size_t                 cols_reg;
    size_t                 rows_reg;
    cfg_t                  cfg;

    // Front-to-back job queue.
    job_t    push_job;
    logic    q_push;
    logic    q_pop;
    logic    q_empty;
    logic    q_full;
    job_t    head_job;

    // Result register of the node sequencer.
    logic    res_valid;
    result_t res;

    assign cfg_ready = 1'b1;

    // Writes beyond the register list are taken and dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            kind_reg <= KIND_STAR;
            width_reg <= WIDTH_BITS'(1);
            edge_reg <= DOF_BITS'(1);
            cell_reg <= DOF_BITS'(1);
            cols_reg <= SIZE_BITS'(1 << COORD_BITS);
            rows_reg <= SIZE_BITS'(1 << COORD_BITS);
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                REG_KIND:  kind_reg <= cfg_data[KIND_BITS-1:0];
                REG_WIDTH: width_reg <= cfg_data[WIDTH_BITS-1:0];
                REG_EDGE:  edge_reg <= cfg_data[DOF_BITS-1:0];
                REG_CELL:  cell_reg <= cfg_data[DOF_BITS-1:0];
                REG_COLS:  cols_reg <= cfg_data[SIZE_BITS-1:0];
                REG_ROWS:  rows_reg <= cfg_data[SIZE_BITS-1:0];
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        cfg.kind = kind_reg;
        cfg.width = width_reg;
        cfg.edge_dofs = edge_reg;
        cfg.cell_dofs = cell_reg;
        cfg.cols = cols_reg;
        cfg.rows = rows_reg;
    end

    // The classifier turns each accepted cell into a job, or drops it when it has no nodes.
    sng_front u_front (
        .push   (push),
        .full   (full),
        .cell_x (cell_x),
        .cell_y (cell_y),
        .cfg    (cfg),
        .q_full (q_full),
        .q_push (q_push),
        .job    (push_job)
    );

    sng_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (q_push),
        .wr_job  (push_job),
        .rd_en   (q_pop),
        .rd_job  (head_job),
        .q_empty (q_empty),
        .q_full  (q_full)
    );

    // The sequencer walks the head job one node per unstalled cycle into the result register.
    sng_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (head_job),
        .head_valid (!q_empty),
        .head_pop   (q_pop),
        .pop        (pop),
        .out_valid  (res_valid),
        .out_res    (res)
    );

    assign empty = !res_valid;
    assign point_x = res.px;
    assign point_y = res.py;
    assign node_edge_dofs = res.edge_dofs;
    assign node_cell_dofs = res.cell_dofs;
    assign unsupported = res.unsupported;
    assign last = res.last;

`ifndef SYNTHESIS
    // The classifier never writes into a full queue.
    assert property (@(posedge clk) disable iff (!rst_n) q_push |-> !q_full)
        else $error("job pushed into a full queue");

    // The sequencer retires only a job that is present.
    assert property (@(posedge clk) disable iff (!rst_n) q_pop |-> !q_empty)
        else $error("job retired from an empty queue");

    // The error request is always a single, final request.
    assert property (@(posedge clk) disable iff (!rst_n) (!empty && unsupported) |-> last)
        else $error("unsupported request without last");

    // A regular node always carries some components.
    assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !unsupported) |-> (node_edge_dofs != '0 || node_cell_dofs != '0))
        else $error("node emitted with no components");
`endif

endmodule
